>>> hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W = 64;
    localparam int DIG_N   = 20;
    localparam int DATA_W  = DIG_N * 4;
    localparam int DIG_W   = 5;

    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;

    localparam logic [1:0] FMT_DECIMAL = 2'd0;
    localparam logic [1:0] FMT_COMMAS  = 2'd1;
    localparam logic [1:0] FMT_HEX     = 2'd2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_word_t;

    typedef enum logic [1:0] {
        JOB_CHAR,
        JOB_DEC,
        JOB_COMMA,
        JOB_HEX
    } job_mode_t;

    // data: BCD digits, hex value or character byte, least significant first
    typedef struct packed {
        job_mode_t         mode;
        logic              neg;
        logic [DATA_W-1:0] data;
        logic [DIG_W-1:0]  ndig;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return HEX_DIGITS[d];
    endfunction

endpackage

>>> hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats 64-bit unsigned, 32-bit signed or raw character words as ASCII,
// one character per output word, last set on the final character.
// ----------------------------------------------------------------------------
// Usage:
//   src_valid/src_ready/src_word: one word per value (kind, value).
//   dst_valid/dst_ready/dst_word: one ASCII character per word, last marks
//     the final character of each input word (1 to 26 words per item).
//   cfg_valid/cfg_ready/cfg_data: number format, always ready; write it only
//     while the block is idle. Reset selects plain decimal.
// Flow: decimal words take 64 double dabble steps in the front before
//   queueing; hex and character words go to the queue without them.
//   The back part loads one job while idle, then emits one character
//   per cycle while dst_ready is high, through its output register.
//   The front takes no new word until it has queued the last one; the
//   back loads no new job until it has emitted the last character.
//   The job queue lets the front convert the next value while the back
//   still emits the previous text.
// Reset clears the queue and the output valid flag. When the receiver
//   stalls, dst_word holds, the queue fills and src_ready drops.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  i2a_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_ready,
    output i2a_pkg::out_word_t dst_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);

    logic [1:0]       fmt_reg;
    logic             push;
    logic             pop;
    i2a_pkg::job_t    push_job;
    i2a_pkg::job_t    pop_job;
    i2a_pkg::q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= i2a_pkg::FMT_DECIMAL;
        else if (cfg_valid)
            fmt_reg <= cfg_data;
    end

    i2a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .fmt       (fmt_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    i2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    i2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_job   (pop_job),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word)
    );

`ifndef SYNTHESIS
    a_front_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) |=> !src_ready
    ) else $error("front accepted back-to-back words");

    a_queue_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty)
    ) else $error("job queue both full and empty");

    a_pop_only_when_idle_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |=> !(dst_valid && $changed(dst_word) && !$past(dst_ready))
    ) else $error("output word changed while stalled after job load");
`endif

endmodule

>>> hdl/i2a_front.sv
// ----------------------------------------------------------------------------
// i2a_front
// Accepts input words, classifies them and converts decimal magnitudes to
// BCD with a one-bit-per-cycle double dabble before queueing the job.
// ----------------------------------------------------------------------------
module i2a_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  i2a_pkg::in_word_t src_word,
    input  logic [1:0]        fmt,
    input  i2a_pkg::q_stat_t  q_stat,
    output logic              push,
    output i2a_pkg::job_t     push_job
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } state_t;

    state_t                           state_reg, state_next;
    i2a_pkg::job_mode_t               mode_reg, mode_next;
    logic                             neg_reg, neg_next;
    logic [i2a_pkg::DATA_W-1:0]       data_reg, data_next;
    logic [i2a_pkg::VALUE_W-1:0]      bin_reg, bin_next;
    logic [5:0]                       cnt_reg, cnt_next;

    logic [i2a_pkg::VALUE_W-1:0]      mag;
    logic                             neg_in;
    logic [31:0]                      v32;
    i2a_pkg::job_mode_t               mode_in;
    logic [i2a_pkg::DATA_W-1:0]       bcd_adj;
    logic [i2a_pkg::DIG_W-1:0]        ndig;

    assign src_ready = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH);

    always_comb
    begin
        v32    = src_word.value[31:0];
        neg_in = 1'b0;
        mag    = src_word.value;
        if (src_word.kind == i2a_pkg::KIND_SIGNED)
        begin
            neg_in = v32[31];
            mag    = {32'd0, (v32[31] ? (32'd0 - v32) : v32)};
        end
        if (src_word.kind inside {i2a_pkg::KIND_UNSIGNED, i2a_pkg::KIND_SIGNED})
        begin
            case (fmt)
                i2a_pkg::FMT_HEX:    mode_in = i2a_pkg::JOB_HEX;
                i2a_pkg::FMT_COMMAS: mode_in = i2a_pkg::JOB_COMMA;
                default:             mode_in = i2a_pkg::JOB_DEC;
            endcase
        end
        else
        begin
            mode_in = i2a_pkg::JOB_CHAR;
        end
    end

    always_comb
    begin
        for (int i = 0; i < i2a_pkg::DIG_N; i++)
        begin
            bcd_adj[i*4 +: 4] = (data_reg[i*4 +: 4] >= 4'd5) ?
                                (data_reg[i*4 +: 4] + 4'd3) : data_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        ndig = i2a_pkg::DIG_W'(1);
        for (int i = 0; i < i2a_pkg::DIG_N; i++)
        begin
            if (data_reg[i*4 +: 4] != 4'd0)
                ndig = i2a_pkg::DIG_W'(i + 1);
        end
    end

    assign push_job = '{mode: mode_reg, neg: neg_reg, data: data_reg, ndig: ndig};

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        neg_next   = neg_reg;
        data_next  = data_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (src_valid)
                begin
                    mode_next = mode_in;
                    neg_next  = neg_in;
                    bin_next  = mag;
                    cnt_next  = '0;
                    case (mode_in)
                        i2a_pkg::JOB_CHAR:
                        begin
                            data_next  = {{(i2a_pkg::DATA_W-8){1'b0}}, src_word.value[7:0]};
                            state_next = F_PUSH;
                        end
                        i2a_pkg::JOB_HEX:
                        begin
                            data_next  = {{(i2a_pkg::DATA_W-i2a_pkg::VALUE_W){1'b0}}, mag};
                            state_next = F_PUSH;
                        end
                        default:
                        begin
                            data_next  = '0;
                            state_next = F_CONV;
                        end
                    endcase
                end
            end
            F_CONV:
            begin
                {data_next, bin_next} = {bcd_adj[i2a_pkg::DATA_W-2:0], bin_reg, 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        neg_reg  <= neg_next;
        data_reg <= data_next;
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
    end

endmodule

>>> hdl/i2a_fifo.sv
// ----------------------------------------------------------------------------
// i2a_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module i2a_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2a_pkg::job_t    push_job,
    input  logic             pop,
    output i2a_pkg::job_t    pop_job,
    output i2a_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2a_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hdl/i2a_back.sv
// ----------------------------------------------------------------------------
// i2a_back
// Character sequencer: pops a job, emits a raw byte or sign, prefix, digits
// and separators through an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2a_back (
    input  logic               clk,
    input  logic               rst_n,
    input  i2a_pkg::q_stat_t   q_stat,
    output logic               pop,
    input  i2a_pkg::job_t      pop_job,
    output logic               dst_valid,
    input  logic               dst_ready,
    output i2a_pkg::out_word_t dst_word
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHAR,
        B_SIGN,
        B_ZERO,
        B_X,
        B_DIGIT,
        B_SEP
    } state_t;

    state_t                    state_reg, state_next;
    i2a_pkg::job_t             job_reg, job_next;
    logic [i2a_pkg::DIG_W-1:0] di_reg, di_next;
    logic                      valid_reg, valid_next;
    i2a_pkg::out_word_t        word_reg, word_next;

    logic                      adv;
    logic [3:0]                nib;
    logic                      sep;
    logic [i2a_pkg::DIG_W-1:0] first_di;

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;
    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign adv       = (state_reg != B_IDLE) && (!valid_reg || dst_ready);
    assign nib       = job_reg.data[{di_reg, 2'b00} +: 4];

    always_comb
    begin
        if (job_reg.mode == i2a_pkg::JOB_HEX)
            sep = (di_reg inside {5'd12, 5'd8, 5'd4});
        else if (job_reg.mode == i2a_pkg::JOB_COMMA)
            sep = (di_reg inside {5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18});
        else
            sep = 1'b0;
    end

    assign first_di = job_reg.ndig - i2a_pkg::DIG_W'(1);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        di_next    = di_reg;
        word_next  = word_reg;
        valid_next = (valid_reg && !dst_ready) ? 1'b1 : 1'b0;
        if (pop)
        begin
            job_next = pop_job;
            di_next  = pop_job.ndig - i2a_pkg::DIG_W'(1);
            if (pop_job.mode == i2a_pkg::JOB_CHAR)
                state_next = B_CHAR;
            else if (pop_job.neg)
                state_next = B_SIGN;
            else if (pop_job.mode == i2a_pkg::JOB_HEX)
                state_next = B_ZERO;
            else
                state_next = B_DIGIT;
        end
        if (adv)
        begin
            valid_next     = 1'b1;
            word_next.last = 1'b0;
            case (state_reg)
                B_CHAR:
                begin
                    word_next.character = job_reg.data[7:0];
                    word_next.last      = 1'b1;
                    state_next          = B_IDLE;
                end
                B_SIGN:
                begin
                    word_next.character = i2a_pkg::ASCII_MINUS;
                    di_next             = first_di;
                    state_next          = (job_reg.mode == i2a_pkg::JOB_HEX) ? B_ZERO : B_DIGIT;
                end
                B_ZERO:
                begin
                    word_next.character = i2a_pkg::ASCII_ZERO;
                    state_next          = B_X;
                end
                B_X:
                begin
                    word_next.character = i2a_pkg::ASCII_X;
                    di_next             = i2a_pkg::DIG_W'(15);
                    state_next          = B_DIGIT;
                end
                B_DIGIT:
                begin
                    word_next.character = i2a_pkg::hex_char(nib);
                    if (di_reg == '0)
                    begin
                        word_next.last = 1'b1;
                        state_next     = B_IDLE;
                    end
                    else
                    begin
                        di_next    = di_reg - i2a_pkg::DIG_W'(1);
                        state_next = sep ? B_SEP : B_DIGIT;
                    end
                end
                B_SEP:
                begin
                    word_next.character = (job_reg.mode == i2a_pkg::JOB_HEX) ?
                                          i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_COMMA;
                    state_next          = B_DIGIT;
                end
                default:
                begin
                    state_next = B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        di_reg   <= di_next;
        word_reg <= word_next;
    end

endmodule

>>> bench/i2a_text_monitor.sv
// ----------------------------------------------------------------------------
// i2a_text_monitor
// Watches the source, destination and format channels of the integer to
// ASCII formatter, predicts the text of every accepted word under the
// current number format and compares each output character in order.
// ----------------------------------------------------------------------------
module i2a_text_monitor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_ready,
    input  i2a_pkg::in_word_t  src_word,
    input  logic               dst_valid,
    input  logic               dst_ready,
    input  i2a_pkg::out_word_t dst_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    output int                 mismatches,
    output int                 outstanding,
    output int                 chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    logic [1:0]         number_fmt;
    i2a_pkg::out_word_t expected_chars [$];
    i2a_pkg::out_word_t oldest;
    int                 n_bad;
    int                 n_chars;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            return i2a_pkg::ASCII_ZERO + 8'(d);
        return ASCII_UPPER_A + 8'(d - 4'd10);
    endfunction

    function automatic void format_text(input logic [1:0] kind, input logic [63:0] value,
                                        input logic [1:0] fmt);
        logic [7:0]         text [$];
        logic [3:0]         dec [20];
        logic [63:0]        mag;
        logic [31:0]        v32;
        i2a_pkg::out_word_t w;
        int                 len;
        int                 i;
        mag = value;
        if (kind == i2a_pkg::KIND_SIGNED)
        begin
            v32 = value[31:0];
            if (v32[31])
            begin
                text.push_back(i2a_pkg::ASCII_MINUS);
                v32 = 32'd0 - v32;
            end
            mag = {32'd0, v32};
        end
        if (!(kind inside {i2a_pkg::KIND_UNSIGNED, i2a_pkg::KIND_SIGNED}))
            text.push_back(value[7:0]);
        else if (fmt == i2a_pkg::FMT_HEX)
        begin
            text.push_back(i2a_pkg::ASCII_ZERO);
            text.push_back(i2a_pkg::ASCII_X);
            for (i = 15; i >= 0; i--)
            begin
                if (i == 11 || i == 7 || i == 3)
                    text.push_back(i2a_pkg::ASCII_MINUS);
                text.push_back(digit_char(mag[i*4 +: 4]));
            end
        end
        else if (mag == 64'd0)
            text.push_back(i2a_pkg::ASCII_ZERO);
        else
        begin
            len = 0;
            while (mag != 64'd0)
            begin
                dec[len] = 4'(mag % 64'd10);
                mag = mag / 64'd10;
                len++;
            end
            for (i = len - 1; i >= 0; i--)
            begin
                text.push_back(digit_char(dec[i]));
                if (fmt == i2a_pkg::FMT_COMMAS && i > 0 && (i % 3) == 0)
                    text.push_back(i2a_pkg::ASCII_COMMA);
            end
        end
        for (i = 0; i < text.size(); i++)
        begin
            w.character = text[i];
            w.last      = (i == text.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_fmt = i2a_pkg::FMT_DECIMAL;
            expected_chars.delete();
            n_bad       = 0;
            n_chars     = 0;
            mismatches  <= 0;
            outstanding <= 0;
            chars_seen  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                number_fmt = cfg_data;
            if (dst_valid && dst_ready)
            begin
                n_chars++;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected output word: character 8'h%02h last %0b",
                           dst_word.character, dst_word.last);
                    n_bad++;
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (dst_word.character !== oldest.character)
                    begin
                        $error("character mismatch: expected 8'h%02h, got 8'h%02h",
                               oldest.character, dst_word.character);
                        n_bad++;
                    end
                    if (dst_word.last !== oldest.last)
                    begin
                        $error("last mismatch: expected %0b, got %0b",
                               oldest.last, dst_word.last);
                        n_bad++;
                    end
                end
            end
            if (src_valid && src_ready)
                format_text(src_word.kind, src_word.value, number_fmt);
            mismatches  <= n_bad;
            outstanding <= expected_chars.size();
            chars_seen  <= n_chars;
        end
    end

endmodule

>>> bench/integer_to_ascii_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives directed and random words (unsigned, signed, character and the spare
// kind) through the formatter under every number format, with random gaps on
// the source and random stalls on the destination; a monitor checks the text.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] FMT_SPARE  = 2'd3;

    localparam int    PHASES          = 8;
    localparam int    ITEMS_PER_PHASE = 51;
    localparam int    SETTLE_CYCLES   = 80;
    localparam int    DRAIN_LIMIT     = 200000;
    localparam int    TAIL_CYCLES     = 150;
    localparam longint RUN_LIMIT_NS   = 64'd3_000_000;

    localparam logic [1:0] PHASE_FMT [PHASES] = '{
        i2a_pkg::FMT_DECIMAL, i2a_pkg::FMT_HEX, i2a_pkg::FMT_COMMAS, FMT_SPARE,
        i2a_pkg::FMT_HEX, i2a_pkg::FMT_DECIMAL, i2a_pkg::FMT_COMMAS, i2a_pkg::FMT_DECIMAL
    };

    logic               clk;
    logic               rst_n;
    logic               src_valid;
    logic               src_ready;
    i2a_pkg::in_word_t  src_word;
    logic               dst_valid;
    logic               dst_ready;
    i2a_pkg::out_word_t dst_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_data;

    int mismatches;
    int outstanding;
    int chars_seen;
    int words_sent;
    int formats_applied;
    bit steady;

    integer_to_ascii_formatter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2a_text_monitor text_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_word    (src_word),
        .dst_valid   (dst_valid),
        .dst_ready   (dst_ready),
        .dst_word    (dst_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .chars_seen  (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // destination stalls
    initial
    begin
        int hold;
        hold = 0;
        dst_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                dst_ready <= 1'b0;
                hold--;
            end
            else
            begin
                dst_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 25)
                    hold = pick_gap();
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [63:0] value);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_word.kind  <= kind;
        src_word.value <= value;
        src_valid      <= 1'b1;
        do @(posedge clk); while (!src_ready);
        words_sent++;
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_format(input logic [1:0] fmt);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= fmt;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        formats_applied++;
    endtask

    task automatic random_item(output logic [1:0] kind, output logic [63:0] value);
        int          r;
        logic [63:0] p10;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = i2a_pkg::KIND_UNSIGNED;
        else if (r < 80)
            kind = i2a_pkg::KIND_SIGNED;
        else if (r < 95)
            kind = KIND_CHAR;
        else
            kind = KIND_SPARE;
        value = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2: value = value >> $urandom_range(1, 63);
            3:
            begin
                p10 = 64'd1;
                repeat ($urandom_range(0, 19)) p10 = p10 * 64'd10;
                value = p10 - 64'($urandom_range(0, 1));
            end
            4: value[31:0] = 32'd0 - 32'($urandom_range(0, 5000));
            default: ;
        endcase
    endtask

    initial
    begin
        logic [1:0]  kind;
        logic [63:0] value;
        int          waited;
        src_valid       = 1'b0;
        src_word        = '0;
        cfg_valid       = 1'b0;
        cfg_data        = i2a_pkg::FMT_DECIMAL;
        rst_n           = 1'b0;
        steady          = 1'b0;
        words_sent      = 0;
        formats_applied = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain decimal out of reset
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd0);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd1);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd999);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd1000);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd10000000000000000000);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_7FFF_FFFF);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_8000_0000);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_FFFF_FFFF);
        send_item(i2a_pkg::KIND_SIGNED, 64'hDEAD_BEEF_0000_002A);
        send_item(KIND_CHAR, 64'h0000_0000_0000_0041);
        send_item(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FF00);
        send_item(KIND_CHAR, 64'h0000_0000_0000_00FF);
        send_item(KIND_SPARE, 64'h1234_5678_9ABC_DE7E);

        set_format(i2a_pkg::FMT_COMMAS);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd1000000);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd999999);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_8000_0000);

        set_format(i2a_pkg::FMT_HEX);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'h0123_4567_89AB_CDEF);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_FFFF_FFFE);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd0);

        set_format(FMT_SPARE);
        send_item(i2a_pkg::KIND_UNSIGNED, 64'd1234567);
        send_item(i2a_pkg::KIND_SIGNED, 64'h0000_0000_FFFF_FF85);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                set_format(2'($urandom_range(0, 3)));
            else
                set_format(PHASE_FMT[p]);
            steady = (p == 2 || p == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    drain();
                random_item(kind, value);
                send_item(kind, value);
            end
            steady = 1'b0;
        end

        src_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d input words and %0d output characters under %0d format writes",
                 words_sent, chars_seen, formats_applied - 1);
        $display("(all four kind codes, all four format codes, random gaps and stalls).");
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/i2a_pkg.sv
hdl/i2a_front.sv
hdl/i2a_fifo.sv
hdl/i2a_back.sv
hdl/integer_to_ascii_formatter.sv
bench/i2a_text_monitor.sv
bench/integer_to_ascii_formatter_tb.sv
